@@ rtl/ppkf_pkg.sv @@
// Shared types, field widths, operation and register codes for the planar
// position Kalman filter. No dependencies; every other file imports it.
`default_nettype none

package ppkf_pkg;

   // Fixed field widths of the transfer payloads and the register port.
   localparam int POS_FIELD_W = 48;
   localparam int SPEED_W     = 24;
   localparam int HEADING_W   = 20;
   localparam int VAR_W       = 32;
   localparam int TIME_STEP_W = 24;
   localparam int OP_W        = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_INIT    = 2'd0;
   localparam logic [OP_W-1:0] OP_PREDICT = 2'd1;
   localparam logic [OP_W-1:0] OP_UPDATE  = 2'd2;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_MEAS_NOISE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROC_NOISE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIME_STEP  = 2'd2;

   // Reset values.
   localparam logic [VAR_W-1:0]       MEAS_NOISE_RESET = 32'd65536;
   localparam logic [VAR_W-1:0]       PROC_NOISE_RESET = 32'd655;
   localparam logic [TIME_STEP_W-1:0] TIME_STEP_RESET  = 24'd6554;
   localparam logic [VAR_W-1:0]       VAR_ONE          = 32'd65536;

   // CORDIC datapath, Q30 angles and coordinates.
   localparam int CORDIC_W = 36;
   localparam logic signed [HEADING_W:0] HALF_TURN_Q16 = 21'sd205887;
   localparam logic signed [HEADING_W:0] FULL_TURN_Q16 = 21'sd411775;
   localparam logic signed [CORDIC_W-1:0] PI_Q30        = 36'sd3373259426;
   localparam logic signed [CORDIC_W-1:0] HALF_PI_Q30   = 36'sd1686629713;
   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN   = 36'sd652032874;

   // Shared multiplier.
   localparam int MUL_W  = 34;
   localparam int PROD_W = 2 * MUL_W;

   // Gain divider: one quotient bit per cycle over a 64-bit dividend.
   localparam int DIV_STEPS = 64;
   localparam int DIV_CNT_W = 6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROTATE,
      ST_MUL_COS,
      ST_MUL_SIN,
      ST_ADD_Y,
      ST_DIVIDE,
      ST_X_HIGH,
      ST_X_LOW,
      ST_X_SUM,
      ST_Y_HIGH,
      ST_Y_LOW,
      ST_Y_SUM,
      ST_VAR_MUL,
      ST_VAR_SET,
      ST_RESPOND
   } ppkf_state_type;

   // Arctangent of 2^-i in Q30, truncated.
   function automatic logic [29:0] atan_q30(input logic [4:0] idx);
      logic [29:0] v;
      case (idx)
         5'd0:  v = 30'd843314856;
         5'd1:  v = 30'd497837829;
         5'd2:  v = 30'd263043836;
         5'd3:  v = 30'd133525158;
         5'd4:  v = 30'd67021686;
         5'd5:  v = 30'd33543515;
         5'd6:  v = 30'd16775850;
         5'd7:  v = 30'd8388437;
         5'd8:  v = 30'd4194282;
         5'd9:  v = 30'd2097149;
         5'd10: v = 30'd1048575;
         5'd11: v = 30'd524287;
         5'd12: v = 30'd262143;
         5'd13: v = 30'd131071;
         5'd14: v = 30'd65535;
         5'd15: v = 30'd32767;
         5'd16: v = 30'd16383;
         5'd17: v = 30'd8191;
         5'd18: v = 30'd4095;
         5'd19: v = 30'd2047;
         5'd20: v = 30'd1023;
         5'd21: v = 30'd511;
         5'd22: v = 30'd255;
         5'd23: v = 30'd127;
         5'd24: v = 30'd63;
         5'd25: v = 30'd31;
         5'd26: v = 30'd15;
         5'd27: v = 30'd7;
         5'd28: v = 30'd3;
         5'd29: v = 30'd1;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

@@ rtl/ppkf_if.sv @@
// Valid/ready channel interfaces for the request and response transfers.
// Depends on ppkf_pkg for the field widths.
`default_nettype none

interface ppkf_req_if;
   import ppkf_pkg::*;
   logic                           valid;
   logic                           ready;
   logic [OP_W-1:0]                operation;
   logic signed [POS_FIELD_W-1:0]  position_x;
   logic signed [POS_FIELD_W-1:0]  position_y;
   logic signed [SPEED_W-1:0]      speed;
   logic signed [HEADING_W-1:0]    heading;

   modport source (output valid, operation, position_x, position_y, speed, heading,
                   input ready);
   modport sink (input valid, operation, position_x, position_y, speed, heading,
                 output ready);
endinterface

interface ppkf_rsp_if;
   import ppkf_pkg::*;
   logic                           valid;
   logic                           ready;
   logic signed [POS_FIELD_W-1:0]  estimate_x;
   logic signed [POS_FIELD_W-1:0]  estimate_y;
   logic [VAR_W-1:0]               variance;

   modport source (output valid, estimate_x, estimate_y, variance, input ready);
   modport sink (input valid, estimate_x, estimate_y, variance, output ready);
endinterface

`default_nettype wire

@@ rtl/ppkf_cordic.sv @@
// Iterative CORDIC rotator: one micro-rotation per cycle gives cos and sin
// of a Q4.16 heading in Q30. Depends on ppkf_pkg.
`default_nettype none

module ppkf_cordic import ppkf_pkg::*; #(
   parameter int STEPS = 18
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [HEADING_W-1:0] heading,
   output logic signed [MUL_W-1:0]    cos_val,
   output logic signed [MUL_W-1:0]    sin_val,
   output logic                       done
);

   localparam int STEP_W = $clog2(STEPS);

   logic signed [CORDIC_W-1:0] x_ff, y_ff, a_ff;
   logic signed [CORDIC_W-1:0] x_in, y_in, a_in;
   logic [STEP_W-1:0]          step_ff;
   logic                       flip_ff, busy_ff, done_ff;

   logic signed [HEADING_W:0]  h_ext, h_wrap;
   logic signed [CORDIC_W-1:0] a_raw, a_start;
   logic                       flip_start;
   logic signed [CORDIC_W-1:0] x_shift, y_shift, atan_step;

   // Wrap into plus or minus pi, then fold the left half plane onto the right.
   always_comb begin
      h_ext = (HEADING_W + 1)'(heading);
      if (h_ext > HALF_TURN_Q16) begin
         h_wrap = h_ext - FULL_TURN_Q16;
      end else if (h_ext < -HALF_TURN_Q16) begin
         h_wrap = h_ext + FULL_TURN_Q16;
      end else begin
         h_wrap = h_ext;
      end
      a_raw = CORDIC_W'(h_wrap) <<< 14;
      flip_start = 1'b1;
      if (a_raw > HALF_PI_Q30) begin
         a_start = a_raw - PI_Q30;
      end else if (a_raw < -HALF_PI_Q30) begin
         a_start = a_raw + PI_Q30;
      end else begin
         a_start = a_raw;
         flip_start = 1'b0;
      end
   end

   always_comb begin
      x_shift = x_ff >>> step_ff;
      y_shift = y_ff >>> step_ff;
      atan_step = CORDIC_W'(atan_q30(5'(step_ff)));
      if (!a_ff[CORDIC_W-1]) begin
         x_in = x_ff - y_shift;
         y_in = y_ff + x_shift;
         a_in = a_ff - atan_step;
      end else begin
         x_in = x_ff + y_shift;
         y_in = y_ff - x_shift;
         a_in = a_ff + atan_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            x_ff    <= CORDIC_GAIN;
            y_ff    <= '0;
            a_ff    <= a_start;
            flip_ff <= flip_start;
            step_ff <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            x_ff    <= x_in;
            y_ff    <= y_in;
            a_ff    <= a_in;
            step_ff <= step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign cos_val = flip_ff ? MUL_W'(-x_ff) : MUL_W'(x_ff);
   assign sin_val = flip_ff ? MUL_W'(-y_ff) : MUL_W'(y_ff);
   assign done    = done_ff;

endmodule

`default_nettype wire

@@ rtl/ppkf_divider.sv @@
// Restoring divider for the filter gain: quotient of dividend * 2^32 over
// a 33-bit divisor, one bit per cycle. Depends on ppkf_pkg.
`default_nettype none

module ppkf_divider import ppkf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [VAR_W-1:0] dividend,
   input  logic [VAR_W:0]   divisor,
   output logic [VAR_W:0]   quotient,
   output logic             done
);

   logic [2*VAR_W-1:0]   num_ff;
   logic [VAR_W:0]       rem_ff, quo_ff, div_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff, done_ff;
   logic [VAR_W+1:0]     trial, trial_sub;
   logic                 fits;

   assign trial     = {rem_ff, num_ff[2*VAR_W-1]};
   assign trial_sub = trial - {1'b0, div_ff};
   assign fits      = trial >= {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            num_ff <= {dividend, {VAR_W{1'b0}}};
            rem_ff <= '0;
            quo_ff <= '0;
            div_ff <= divisor;
            cnt_ff <= '0;
            // A zero divisor means zero gain; finish at once.
            if (divisor == '0) begin
               done_ff <= 1'b1;
            end else begin
               busy_ff <= 1'b1;
            end
         end else if (busy_ff) begin
            num_ff <= num_ff << 1;
            rem_ff <= fits ? trial_sub[VAR_W:0] : trial[VAR_W:0];
            quo_ff <= {quo_ff[VAR_W-1:0], fits};
            cnt_ff <= cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

`default_nettype wire

@@ rtl/planar_position_kalman_filter.sv @@
// Planar position Kalman filter. Each request transfer carries one operation:
// initialize loads the position and resets the variance to one, predict
// dead-reckons the position by speed * time_step along the heading and adds
// the process noise to the variance, and update blends a position fix in
// with gain p / (p + r). Every request produces exactly one response
// transfer with the new estimate and variance. Positions are signed Q32.16
// and saturate at POSITION_BITS; the variance is unsigned Q16.16 and
// saturates at its maximum. The block takes one request at a time: predict
// runs the CORDIC rotator, which makes one micro-rotation per cycle, and
// update runs the bit-serial gain divider followed by five passes through
// the single shared 34 x 34 multiplier. A finished response sits in an
// output register, so the next request is taken while it waits.
// Configuration registers are written through the csr port; the user must
// write them only while idle, as the block itself does not enforce it.
`default_nettype none

module planar_position_kalman_filter import ppkf_pkg::*; #(
   parameter int CORDIC_STEPS  = 18,
   parameter int POSITION_BITS = 48
) (
   input  logic                   clock,
   input  logic                   reset,
   ppkf_req_if.sink               req_chan,
   ppkf_rsp_if.source             rsp_chan,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   localparam int PB    = POSITION_BITS;
   localparam int EXT_W = (PB > POS_FIELD_W) ? PB : POS_FIELD_W;
   localparam int DX_W  = PROD_W - 30;
   localparam int SUM_W = ((PB > DX_W) ? PB : DX_W) + 1;
   localparam logic signed [PB-1:0] POS_MAX = {1'b0, {(PB - 1){1'b1}}};
   localparam logic signed [PB-1:0] POS_MIN = {1'b1, {(PB - 1){1'b0}}};

   ppkf_state_type state_ff, state_in;

   // Configuration registers.
   logic [VAR_W-1:0]       meas_noise_ff, proc_noise_ff;
   logic [TIME_STEP_W-1:0] time_step_ff;

   // Filter state and per-item working registers.
   logic signed [PB-1:0]      est_x_ff, est_y_ff, zx_ff, zy_ff;
   logic [VAR_W-1:0]          est_var_ff;
   logic signed [SPEED_W-1:0] speed_ff;
   logic signed [32:0]        sd_ff;
   logic [VAR_W:0]            k_ff;
   logic [2*VAR_W:0]          acc_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [MUL_W-1:0]   mul_a, mul_b;

   // Response output register.
   logic                          rsp_valid_ff;
   logic signed [POS_FIELD_W-1:0] rsp_x_ff, rsp_y_ff;
   logic [VAR_W-1:0]              rsp_var_ff;

   logic accept, slot_free, cordic_start, div_start, cordic_done, div_done;
   logic signed [MUL_W-1:0] cos_val, sin_val;
   logic [VAR_W:0]          div_quo;

   logic signed [PB-1:0]    clamp_x, clamp_y, est_sel, z_sel, moved, sat_res;
   logic                    sel_y, move_up;
   logic signed [PB:0]      diff;
   logic [PB-1:0]           mag;
   logic [63:0]             mag64, sum64;
   logic signed [SUM_W-1:0] sat_sum;
   logic [VAR_W:0]          var_sum;

   function automatic logic signed [PB-1:0] clamp_in(
      input logic signed [POS_FIELD_W-1:0] v
   );
      logic signed [EXT_W-1:0] e;
      e = EXT_W'(v);
      if (e > EXT_W'(POS_MAX)) begin
         return POS_MAX;
      end else if (e < EXT_W'(POS_MIN)) begin
         return POS_MIN;
      end
      return PB'(e);
   endfunction

   ppkf_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cordic_start),
      .heading (req_chan.heading),
      .cos_val (cos_val),
      .sin_val (sin_val),
      .done    (cordic_done)
   );

   ppkf_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (est_var_ff),
      .divisor  ({1'b0, est_var_ff} + {1'b0, meas_noise_ff}),
      .quotient (div_quo),
      .done     (div_done)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;

   assign clamp_x = clamp_in(req_chan.position_x);
   assign clamp_y = clamp_in(req_chan.position_y);

   // The y axis reuses the same move and saturating-add logic as x.
   assign sel_y = (state_ff == ST_ADD_Y) || (state_ff == ST_Y_HIGH) ||
                  (state_ff == ST_Y_LOW) || (state_ff == ST_Y_SUM);
   assign est_sel = sel_y ? est_y_ff : est_x_ff;
   assign z_sel   = sel_y ? zy_ff : zx_ff;

   // Update: move toward the fix by |z - x| * k / 2^32, split into a high
   // and a low 32-bit partial product so the result rounds toward the old
   // estimate.
   always_comb begin
      diff    = (PB + 1)'(z_sel) - (PB + 1)'(est_sel);
      move_up = !diff[PB];
      mag     = move_up ? PB'(diff) : PB'(-diff);
      mag64   = 64'(mag);
      sum64   = acc_ff[63:0] + 64'(prod_ff[2*VAR_W:VAR_W]);
      moved   = move_up ? est_sel + PB'(sum64) : est_sel - PB'(sum64);
   end

   // Predict: saturating add of the displacement floor(sd * trig / 2^30).
   always_comb begin
      sat_sum = SUM_W'(est_sel) + SUM_W'($signed(prod_ff[PROD_W-1:30]));
      if (sat_sum > SUM_W'(POS_MAX)) begin
         sat_res = POS_MAX;
      end else if (sat_sum < SUM_W'(POS_MIN)) begin
         sat_res = POS_MIN;
      end else begin
         sat_res = PB'(sat_sum);
      end
   end

   assign var_sum = {1'b0, est_var_ff} + {1'b0, proc_noise_ff};

   // Sequencer: next state, unit starts and the shared multiplier operands.
   always_comb begin
      state_in     = state_ff;
      cordic_start = 1'b0;
      div_start    = 1'b0;
      mul_a        = MUL_W'(speed_ff);
      mul_b        = MUL_W'(time_step_ff);
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_chan.operation)
                  OP_PREDICT: begin
                     cordic_start = 1'b1;
                     state_in     = ST_ROTATE;
                  end
                  OP_UPDATE: begin
                     div_start = 1'b1;
                     state_in  = ST_DIVIDE;
                  end
                  default: state_in = ST_RESPOND;
               endcase
            end
         end
         ST_ROTATE: begin
            if (cordic_done) begin
               state_in = ST_MUL_COS;
            end
         end
         ST_MUL_COS: begin
            mul_a    = MUL_W'(sd_ff);
            mul_b    = cos_val;
            state_in = ST_MUL_SIN;
         end
         ST_MUL_SIN: begin
            mul_a    = MUL_W'(sd_ff);
            mul_b    = sin_val;
            state_in = ST_ADD_Y;
         end
         ST_ADD_Y: state_in = ST_RESPOND;
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_X_HIGH;
            end
         end
         ST_X_HIGH, ST_Y_HIGH: begin
            mul_a    = MUL_W'(mag64[63:32]);
            mul_b    = MUL_W'(k_ff);
            state_in = (state_ff == ST_X_HIGH) ? ST_X_LOW : ST_Y_LOW;
         end
         ST_X_LOW, ST_Y_LOW: begin
            mul_a    = MUL_W'(mag64[31:0]);
            mul_b    = MUL_W'(k_ff);
            state_in = (state_ff == ST_X_LOW) ? ST_X_SUM : ST_Y_SUM;
         end
         ST_X_SUM: state_in = ST_Y_HIGH;
         ST_Y_SUM: state_in = ST_VAR_MUL;
         ST_VAR_MUL: begin
            mul_a    = MUL_W'(est_var_ff);
            mul_b    = MUL_W'({1'b1, {VAR_W{1'b0}}} - k_ff);
            state_in = ST_VAR_SET;
         end
         ST_VAR_SET: state_in = ST_RESPOND;
         ST_RESPOND: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (reset) begin
         meas_noise_ff <= MEAS_NOISE_RESET;
         proc_noise_ff <= PROC_NOISE_RESET;
         time_step_ff  <= TIME_STEP_RESET;
         est_x_ff      <= '0;
         est_y_ff      <= '0;
         est_var_ff    <= VAR_ONE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_MEAS_NOISE: meas_noise_ff <= csr_write_data;
               CSR_PROC_NOISE: proc_noise_ff <= csr_write_data;
               CSR_TIME_STEP:  time_step_ff  <= csr_write_data[TIME_STEP_W-1:0];
               default: ;
            endcase
         end
         // In the respond state the output register is reloaded below instead.
         if (rsp_valid_ff && rsp_chan.ready && (state_ff != ST_RESPOND)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  zx_ff    <= clamp_x;
                  zy_ff    <= clamp_y;
                  speed_ff <= req_chan.speed;
                  if (req_chan.operation == OP_INIT) begin
                     est_x_ff   <= clamp_x;
                     est_y_ff   <= clamp_y;
                     est_var_ff <= VAR_ONE;
                  end
               end
            end
            // The product of speed and time step is ready while rotating.
            ST_ROTATE: sd_ff <= prod_ff[48:16];
            ST_MUL_SIN: est_x_ff <= sat_res;
            ST_ADD_Y: begin
               est_y_ff   <= sat_res;
               est_var_ff <= var_sum[VAR_W] ? {VAR_W{1'b1}} : var_sum[VAR_W-1:0];
            end
            ST_DIVIDE: begin
               if (div_done) begin
                  k_ff <= div_quo;
               end
            end
            ST_X_LOW, ST_Y_LOW: acc_ff <= prod_ff[2*VAR_W:0];
            ST_X_SUM: est_x_ff <= moved;
            ST_Y_SUM: est_y_ff <= moved;
            ST_VAR_SET: est_var_ff <= prod_ff[2*VAR_W-1:VAR_W];
            ST_RESPOND: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_x_ff     <= POS_FIELD_W'(EXT_W'(est_x_ff));
                  rsp_y_ff     <= POS_FIELD_W'(EXT_W'(est_y_ff));
                  rsp_var_ff   <= est_var_ff;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.estimate_x = rsp_x_ff;
   assign rsp_chan.estimate_y = rsp_y_ff;
   assign rsp_chan.variance   = rsp_var_ff;

endmodule

`default_nettype wire
